// ----- rtl/core/pfa_pkg.sv -----
package pfa_pkg;

	localparam int PAGE_W       = 15;
	localparam int NUM_PAGES    = 1 << PAGE_W;
	localparam int CFG_W        = 16;
	localparam int REF_BITS_DEF = 16;
	localparam int REF_OUT_W    = 16;

	localparam logic [CFG_W-1:0] RESERVED_RESET = CFG_W'(32'h0030_0000 / 4096);
	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(NUM_PAGES - 1);

	localparam logic [2:0] REQ_INIT   = 3'd0;
	localparam logic [2:0] REQ_ALLOC  = 3'd1;
	localparam logic [2:0] REQ_FREE   = 3'd2;
	localparam logic [2:0] REQ_INCREF = 3'd3;
	localparam logic [2:0] REQ_DECREF = 3'd4;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_OOM         = 3'd1;
	localparam logic [2:0] STAT_REF_NONZERO = 3'd2;
	localparam logic [2:0] STAT_DOUBLE_FREE = 3'd3;
	localparam logic [2:0] STAT_OVERFLOW    = 3'd4;
	localparam logic [2:0] STAT_UNDERFLOW   = 3'd5;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [PAGE_W-1:0] page_index;
		logic              zero_fill;
	} pfa_req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [PAGE_W-1:0]    page_out;
		logic [REF_OUT_W-1:0] ref_count_out;
		logic                 zero_request;
		logic                 was_freed;
	} pfa_rsp_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic sweep_init;
		logic exec;
	} pfa_cmd_t;

	typedef struct packed {
		logic req_is_init;
		logic sweep_last;
		logic out_free;
	} pfa_sts_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_EXEC
	} pfa_state_t;

endpackage

// ----- rtl/core/page_frame_allocator_refcount.sv -----
// Page frame allocator with a LIFO free list in next-link memory and a
// reference count per page. A request reads the single-port link, count and
// free-flag memories when it is taken, then updates them and loads the result
// register once that register is free; a new request is taken while the previous
// result still waits. Init walks every page, one per cycle. After reset a
// clearing pass over every page zeroes the counts and free flags, and no request
// is taken until it ends; configuration writes are taken at all times.
module page_frame_allocator_refcount
	import pfa_pkg::*;
#(
	parameter int REF_BITS = REF_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  pfa_req_t    req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output pfa_rsp_t    rsp_data
);

	logic [CFG_W-1:0] reserved_pages_q;
	pfa_cmd_t         cmd;
	pfa_sts_t         sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, reserved_pages_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_pages_q <= RESERVED_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			reserved_pages_q <= pwdata[CFG_W-1:0];
		end
	end

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfa_datapath #(
		.REF_BITS (REF_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.reserved_pages (reserved_pages_q),
		.req_data       (req_data),
		.rsp_stall      (rsp_stall),
		.rsp_valid      (rsp_valid),
		.rsp_data       (rsp_data)
	);

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.zero_request) |-> (rsp_data.status == STAT_OK && !rsp_data.was_freed))
		else $error("zero request on a result that is not a good alloc");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.was_freed) |->
			(rsp_data.status == STAT_OK || rsp_data.status == STAT_REF_NONZERO))
		else $error("page pushed with an error status");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status == STAT_OOM) |->
			(rsp_data.page_out == '0 && rsp_data.ref_count_out == '0))
		else $error("out of memory result carries a page");

endmodule

// ----- rtl/core/pfa_ctrl.sv -----
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pfa_sts_t sts,
	output pfa_cmd_t cmd
);

	pfa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = sts.req_is_init ? S_INIT : S_EXEC;
			end
			S_INIT: begin
				if (sts.sweep_last) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			S_INIT: begin
				cmd.sweep      = 1'b1;
				cmd.sweep_init = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/core/pfa_datapath.sv -----
module pfa_datapath
	import pfa_pkg::*;
#(
	parameter int REF_BITS = REF_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pfa_cmd_t         cmd,
	output pfa_sts_t         sts,
	input  logic [CFG_W-1:0] reserved_pages,
	input  pfa_req_t         req_data,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output pfa_rsp_t         rsp_data
);

	logic [REF_BITS-1:0] ref_mem [NUM_PAGES];
	logic                free_mem [NUM_PAGES];
	logic [PAGE_W-1:0]   link_mem [NUM_PAGES];

	logic [PAGE_W-1:0]   head_q, head_d;
	logic                nonempty_q, nonempty_d;
	logic [PAGE_W-1:0]   sweep_idx_q;
	logic                rsp_valid_q;
	pfa_rsp_t            rsp_q, res;

	logic [2:0]          req_q;
	logic [PAGE_W-1:0]   pg_q;
	logic                zf_q;
	logic [REF_BITS-1:0] ref_rd_q;
	logic                free_rd_q;
	logic [PAGE_W-1:0]   link_rd_q;

	logic [PAGE_W-1:0]   rd_addr, wr_addr;
	logic                ref_we, free_we, link_we;
	logic [REF_BITS-1:0] ref_wd, ref_inc, ref_dec;
	logic                free_wd;
	logic [PAGE_W-1:0]   link_wd;
	logic                ex_ref_we, ex_free_we, ex_link_we, ex_free_wd;
	logic [REF_BITS-1:0] ex_ref_wd;
	logic [PAGE_W-1:0]   ex_link_wd;
	logic                idx_ge, lo_in_range, out_free;

	function automatic logic [REF_OUT_W-1:0] ref_out(input logic [REF_BITS-1:0] v);
		logic [REF_BITS+REF_OUT_W-1:0] ext;
		ext = {{REF_OUT_W{1'b0}}, v};
		return ext[REF_OUT_W-1:0];
	endfunction

	assign out_free        = !rsp_valid_q || !rsp_stall;
	assign sts.out_free    = out_free;
	assign sts.sweep_last  = (sweep_idx_q == PAGE_LAST);
	assign sts.req_is_init = (req_data.req_type == REQ_INIT);
	assign rsp_valid       = rsp_valid_q;
	assign rsp_data        = rsp_q;

	assign rd_addr     = (req_data.req_type == REQ_ALLOC) ? head_q : req_data.page_index;
	assign idx_ge      = ({1'b0, sweep_idx_q} >= (PAGE_W+1)'(reserved_pages));
	assign lo_in_range = (reserved_pages[CFG_W-1:PAGE_W] == '0);
	assign ref_inc     = ref_rd_q + REF_BITS'(1);
	assign ref_dec     = ref_rd_q - REF_BITS'(1);

	// request execution, read data already registered
	always_comb begin
		res        = '0;
		res.page_out      = pg_q;
		res.ref_count_out = ref_out(ref_rd_q);
		ex_ref_we  = 1'b0;
		ex_ref_wd  = ref_rd_q;
		ex_free_we = 1'b0;
		ex_free_wd = 1'b0;
		ex_link_we = 1'b0;
		ex_link_wd = nonempty_q ? head_q : pg_q;
		head_d     = head_q;
		nonempty_d = nonempty_q;
		case (req_q)
			REQ_INIT: begin
				res.page_out      = lo_in_range ? reserved_pages[PAGE_W-1:0] : '0;
				res.ref_count_out = '0;
				head_d            = lo_in_range ? reserved_pages[PAGE_W-1:0] : '0;
				nonempty_d        = lo_in_range;
			end
			REQ_ALLOC: begin
				if (!nonempty_q) begin
					res.status        = STAT_OOM;
					res.page_out      = '0;
					res.ref_count_out = '0;
				end else begin
					res.zero_request = zf_q;
					ex_free_we       = 1'b1;
					if (link_rd_q == pg_q) begin
						nonempty_d = 1'b0;
					end else begin
						head_d = link_rd_q;
					end
				end
			end
			REQ_FREE: begin
				if (free_rd_q) begin
					res.status = STAT_DOUBLE_FREE;
				end else begin
					res.status    = (ref_rd_q != '0) ? STAT_REF_NONZERO : STAT_OK;
					res.was_freed = 1'b1;
					ex_free_we    = 1'b1;
					ex_free_wd    = 1'b1;
					ex_link_we    = 1'b1;
					head_d        = pg_q;
					nonempty_d    = 1'b1;
				end
			end
			REQ_INCREF: begin
				if (ref_rd_q == '1) begin
					res.status = STAT_OVERFLOW;
				end else begin
					ex_ref_we         = 1'b1;
					ex_ref_wd         = ref_inc;
					res.ref_count_out = ref_out(ref_inc);
				end
			end
			REQ_DECREF: begin
				if (ref_rd_q == '0) begin
					res.status = STAT_UNDERFLOW;
				end else begin
					ex_ref_we         = 1'b1;
					ex_ref_wd         = ref_dec;
					res.ref_count_out = ref_out(ref_dec);
					if (ref_dec == '0) begin
						if (free_rd_q) begin
							res.status = STAT_DOUBLE_FREE;
						end else begin
							res.was_freed = 1'b1;
							ex_free_we    = 1'b1;
							ex_free_wd    = 1'b1;
							ex_link_we    = 1'b1;
							head_d        = pg_q;
							nonempty_d    = 1'b1;
						end
					end
				end
			end
			default: begin
				res.status = STAT_OK;
			end
		endcase
	end

	// write port: sweep or request
	always_comb begin
		wr_addr = pg_q;
		ref_we  = 1'b0;
		ref_wd  = ex_ref_wd;
		free_we = 1'b0;
		free_wd = ex_free_wd;
		link_we = 1'b0;
		link_wd = ex_link_wd;
		if (cmd.sweep) begin
			wr_addr = sweep_idx_q;
			ref_we  = !cmd.sweep_init || idx_ge;
			ref_wd  = '0;
			free_we = 1'b1;
			free_wd = cmd.sweep_init && idx_ge;
			link_we = cmd.sweep_init && idx_ge;
			link_wd = (sweep_idx_q == PAGE_LAST) ? sweep_idx_q : sweep_idx_q + PAGE_W'(1);
		end else if (cmd.exec) begin
			ref_we  = ex_ref_we;
			free_we = ex_free_we;
			link_we = ex_link_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ref_we) ref_mem[wr_addr] <= ref_wd;
		if (cmd.accept) ref_rd_q <= ref_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[wr_addr] <= free_wd;
		if (cmd.accept) free_rd_q <= free_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[wr_addr] <= link_wd;
		if (cmd.accept) link_rd_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_data.req_type;
			pg_q  <= rd_addr;
			zf_q  <= req_data.zero_fill;
		end
		if (cmd.exec) rsp_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			sweep_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep) sweep_idx_q <= sweep_idx_q + PAGE_W'(1);
			if (cmd.exec) begin
				head_q      <= head_d;
				nonempty_q  <= nonempty_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import pfa_pkg::*;

	localparam logic [2:0] ADDR_RESERVED = 3'd0;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST = 3'd7;
	localparam logic [REF_OUT_W-1:0] COUNT_MAX = '1;
	localparam int WIN_LO = NUM_PAGES - 80;
	localparam int PHASE_ITEMS = 375;
	localparam int HOLD_LEN = 200;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	pfa_req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	pfa_rsp_t rsp_data;

	page_frame_allocator_refcount dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always #10 clk = ~clk;

	// allocator state as the block should hold it
	logic [PAGE_W-1:0] link_mem [NUM_PAGES];
	logic [REF_OUT_W-1:0] count_mem [NUM_PAGES];
	bit listed [NUM_PAGES];
	logic [PAGE_W-1:0] head_pg;
	bit list_live;
	logic [CFG_W-1:0] reserved_cfg;

	pfa_rsp_t expected_rsp [$];
	pfa_rsp_t want_rsp;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int inits_sent = 0;
	int idle_cycles = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_cnt = 0;
	bit steady = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
	endtask

	function automatic void push_page(input logic [PAGE_W-1:0] pg);
		link_mem[pg] = list_live ? head_pg : pg;
		head_pg = pg;
		list_live = 1'b1;
		listed[pg] = 1'b1;
	endfunction

	function automatic pfa_rsp_t apply_request(input pfa_req_t item);
		pfa_rsp_t r;
		logic [PAGE_W-1:0] pg;
		logic [PAGE_W-1:0] got;
		int lo;
		r = '0;
		pg = item.page_index;
		case (item.req_type)
			REQ_INIT: begin
				lo = int'(reserved_cfg);
				for (int i = 0; i < NUM_PAGES; i++)
					listed[i] = 1'b0;
				list_live = 1'b0;
				head_pg = '0;
				for (int i = NUM_PAGES; i > lo; i--) begin
					count_mem[i-1] = '0;
					push_page(PAGE_W'(i - 1));
				end
				r.status = STAT_OK;
				r.page_out = list_live ? head_pg : '0;
			end
			REQ_ALLOC: begin
				if (!list_live) begin
					r.status = STAT_OOM;
				end else begin
					got = head_pg;
					if (link_mem[got] == got)
						list_live = 1'b0;
					else
						head_pg = link_mem[got];
					listed[got] = 1'b0;
					r.status = STAT_OK;
					r.page_out = got;
					r.ref_count_out = count_mem[got];
					r.zero_request = item.zero_fill;
				end
			end
			REQ_FREE: begin
				r.page_out = pg;
				r.ref_count_out = count_mem[pg];
				if (listed[pg]) begin
					r.status = STAT_DOUBLE_FREE;
				end else begin
					r.status = (count_mem[pg] != '0) ? STAT_REF_NONZERO : STAT_OK;
					push_page(pg);
					r.was_freed = 1'b1;
				end
			end
			REQ_INCREF: begin
				r.page_out = pg;
				if (count_mem[pg] == COUNT_MAX) begin
					r.status = STAT_OVERFLOW;
				end else begin
					count_mem[pg] = count_mem[pg] + 1'b1;
					r.status = STAT_OK;
				end
				r.ref_count_out = count_mem[pg];
			end
			REQ_DECREF: begin
				r.page_out = pg;
				if (count_mem[pg] == '0) begin
					r.status = STAT_UNDERFLOW;
				end else begin
					count_mem[pg] = count_mem[pg] - 1'b1;
					r.ref_count_out = count_mem[pg];
					r.status = STAT_OK;
					if (count_mem[pg] == '0) begin
						if (listed[pg]) begin
							r.status = STAT_DOUBLE_FREE;
						end else begin
							push_page(pg);
							r.was_freed = 1'b1;
						end
					end
				end
			end
			default: begin
				r.status = STAT_OK;
				r.page_out = pg;
				r.ref_count_out = count_mem[pg];
			end
		endcase
		return r;
	endfunction

	function automatic pfa_req_t make_req(input logic [2:0] kind, input logic [PAGE_W-1:0] pg,
			input logic zf);
		pfa_req_t item;
		item.req_type = kind;
		item.page_index = pg;
		item.zero_fill = zf;
		return item;
	endfunction

	task automatic send_req(input pfa_req_t item);
		while (!steady && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		expected_rsp.push_back(apply_request(item));
		items_sent++;
		if (item.req_type == REQ_INIT)
			inits_sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rsp.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reserved(input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_RESERVED;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		reserved_cfg = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value))
			report_mismatch("reserved_pages readback", int'(prdata), int'(value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("result beat with nothing pending", int'(rsp_data), 0);
			end else begin
				want_rsp = expected_rsp.pop_front();
				results_checked++;
				if (rsp_data.status !== want_rsp.status)
					report_mismatch("status", int'(rsp_data.status), int'(want_rsp.status));
				if (rsp_data.page_out !== want_rsp.page_out)
					report_mismatch("page_out", int'(rsp_data.page_out),
						int'(want_rsp.page_out));
				if (rsp_data.ref_count_out !== want_rsp.ref_count_out)
					report_mismatch("ref_count_out", int'(rsp_data.ref_count_out),
						int'(want_rsp.ref_count_out));
				if (rsp_data.zero_request !== want_rsp.zero_request)
					report_mismatch("zero_request", int'(rsp_data.zero_request),
						int'(want_rsp.zero_request));
				if (rsp_data.was_freed !== want_rsp.was_freed)
					report_mismatch("was_freed", int'(rsp_data.was_freed),
						int'(want_rsp.was_freed));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp_stall <= 1'b1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_cnt <= HOLD_LEN;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !steady && ($urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results pending", idle_cycles,
				expected_rsp.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		// before any init: empty list, count edge cases on page 5 and the last page
		send_req(make_req(REQ_ALLOC, '0, 1'b1));
		send_req(make_req(REQ_DECREF, 15'd5, 1'b0));
		send_req(make_req(REQ_INCREF, 15'd5, 1'b0));
		send_req(make_req(REQ_FREE, 15'd5, 1'b0));
		send_req(make_req(REQ_FREE, 15'd5, 1'b1));
		send_req(make_req(REQ_DECREF, 15'd5, 1'b0));
		send_req(make_req(REQ_SPARE_FIRST, PAGE_LAST, 1'b1));
		send_req(make_req(3'd6, '0, 1'b0));
		send_req(make_req(REQ_SPARE_LAST, 15'h5555, 1'b1));
		send_req(make_req(REQ_ALLOC, 15'h2aaa, 1'b1));
		send_req(make_req(REQ_ALLOC, '0, 1'b0));
		send_req(make_req(REQ_INCREF, PAGE_LAST, 1'b0));
		send_req(make_req(REQ_INCREF, PAGE_LAST, 1'b0));
		send_req(make_req(REQ_DECREF, PAGE_LAST, 1'b0));
		send_req(make_req(REQ_DECREF, PAGE_LAST, 1'b0));
		send_req(make_req(REQ_ALLOC, '0, 1'b0));
		settle();
		// whole memory on the list
		write_reserved('0);
		send_req(make_req(REQ_INIT, '0, 1'b0));
		send_req(make_req(REQ_ALLOC, '0, 1'b1));
		send_req(make_req(REQ_ALLOC, '0, 1'b0));
		send_req(make_req(REQ_FREE, '0, 1'b0));
		send_req(make_req(REQ_ALLOC, '0, 1'b1));
		settle();
		// boundary past the last page leaves the list empty
		write_reserved(16'(NUM_PAGES));
		send_req(make_req(REQ_INIT, PAGE_LAST, 1'b1));
		send_req(make_req(REQ_ALLOC, '0, 1'b1));
		send_req(make_req(REQ_FREE, PAGE_LAST, 1'b0));
		settle();
	endtask

	task automatic test_count_updates();
		steady = 1'b1;
		for (int i = 0; i < 8; i++)
			send_req(make_req(REQ_INCREF, 15'd4660, 1'b0));
		send_req(make_req(REQ_DECREF, 15'd4660, 1'b0));
		send_req(make_req(REQ_FREE, 15'd4660, 1'b0));
		send_req(make_req(REQ_INCREF, 15'd4660, 1'b0));
		// count back to zero on a page that is already listed
		for (int i = 0; i < 8; i++)
			send_req(make_req(REQ_DECREF, 15'd4660, 1'b0));
		send_req(make_req(REQ_DECREF, 15'd4660, 1'b0));
		settle();
		steady = 1'b0;
	endtask

	task automatic test_default_boundary();
		write_reserved(RESERVED_RESET);
		send_req(make_req(REQ_INIT, '0, 1'b0));
		send_req(make_req(REQ_ALLOC, '0, 1'b1));
		send_req(make_req(REQ_ALLOC, '0, 1'b0));
		settle();
	endtask

	task automatic test_random_mix();
		logic [CFG_W-1:0] phase_res [4];
		pfa_req_t item;
		int unsigned roll;
		phase_res = '{16'd32700, 16'(NUM_PAGES), 16'd32740, 16'(NUM_PAGES - 1)};
		for (int p = 0; p < 4; p++) begin
			write_reserved(phase_res[p]);
			send_req(make_req(REQ_INIT, 15'($urandom), 1'($urandom)));
			steady = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 150)
					hold_asked++;
				roll = $urandom_range(99);
				if (roll < 30)
					item.req_type = REQ_ALLOC;
				else if (roll < 50)
					item.req_type = REQ_FREE;
				else if (roll < 72)
					item.req_type = REQ_INCREF;
				else if (roll < 94)
					item.req_type = REQ_DECREF;
				else
					item.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
				// mostly pages in a small window near the top, some anywhere
				if ($urandom_range(9) == 0)
					item.page_index = PAGE_W'($urandom);
				else
					item.page_index = PAGE_W'($urandom_range(WIN_LO, int'(PAGE_LAST)));
				item.zero_fill = 1'($urandom);
				send_req(item);
			end
			settle();
			steady = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_PAGES; i++) begin
			link_mem[i] = '0;
			count_mem[i] = '0;
			listed[i] = 1'b0;
		end
		head_pg = '0;
		list_live = 1'b0;
		reserved_cfg = RESERVED_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_updates();
		test_default_boundary();
		test_random_mix();
		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d requests (%0d inits), %0d results checked", items_sent,
			inits_sent, results_checked);
		$display("boundaries 0, default, near top and past the end; count updates; back-pressure");
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/pfa_pkg.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_datapath.sv
rtl/core/page_frame_allocator_refcount.sv
test/testbench.sv
